// ----- rtl/ddf_pkg.sv -----
// shared types and constants for the decimal digit formatter
// no dependencies; used by the interfaces and every module of the block

package ddf_pkg;

	localparam int VALUE_W      = 16;
	localparam int COUNT_W      = 3;
	localparam int COL_W        = 8;
	localparam int PAGE_W       = 3;
	localparam int CHAR_W       = 6;
	localparam int FH_W         = 8;
	localparam int DIG_W        = 4;
	localparam int MAX_DIGITS_DEF = 5;
	localparam int STEP_CNT_W   = $clog2(VALUE_W);

	localparam logic [FH_W-1:0]   FH_RESET   = 8'd16;
	localparam logic [CHAR_W-1:0] BLANK_CODE = 6'd32;
	localparam logic [CHAR_W-1:0] ZERO_CODE  = 6'd48;
	localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(VALUE_W - 1);

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] digit_count;
		logic [COL_W-1:0]   start_column;
		logic [PAGE_W-1:0]  page;
	} item_in_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic [COL_W-1:0]  column;
		logic [PAGE_W-1:0] page_out;
		logic              last;
	} item_out_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic shift;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_empty;
		logic out_free;
		logic last_digit;
	} sts_t;

endpackage

// ----- rtl/ddf_ifs.sv -----
// valid/ready channel interfaces for input items, result items and config writes
// depends on ddf_pkg

interface ddf_in_if;
	logic              valid;
	logic              ready;
	ddf_pkg::item_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ddf_out_if;
	logic               valid;
	logic               ready;
	ddf_pkg::item_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ddf_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [ddf_pkg::FH_W-1:0]  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/ddf_datapath.sv -----
// datapath: shift-add-3 binary to bcd converter, digit emitter, output register
// depends on ddf_pkg

module ddf_datapath #(
	parameter int MAX_DIGITS = ddf_pkg::MAX_DIGITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ddf_pkg::cmd_t                cmd,
	output ddf_pkg::sts_t                sts,
	input  ddf_pkg::item_in_t            in_data,
	input  logic                         cfg_wr,
	input  logic [ddf_pkg::FH_W-1:0]     cfg_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output ddf_pkg::item_out_t           out_data
);

	localparam int BCD_W = ddf_pkg::DIG_W * MAX_DIGITS;
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam logic [ddf_pkg::COUNT_W-1:0] MAX_CNT = ddf_pkg::COUNT_W'(MAX_DIGITS);
	localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

	logic [ddf_pkg::FH_W-1:0]    font_height_q;
	logic [ddf_pkg::VALUE_W-1:0] bin_q;
	logic [BCD_W-1:0]            bcd_q;
	logic [CNT_W-1:0]            rem_q;
	logic [ddf_pkg::COL_W-1:0]   col_q;
	logic [ddf_pkg::PAGE_W-1:0]  page_q;
	logic                        shown_q;
	logic                        out_valid_q;
	ddf_pkg::item_out_t          out_q;

	logic [ddf_pkg::COUNT_W-1:0] cnt_clamp;
	logic [BCD_W-1:0]            adj_v;
	logic [ddf_pkg::DIG_W-1:0]   dig_a [MAX_DIGITS];
	logic [IDX_W-1:0]            idx;
	logic [ddf_pkg::DIG_W-1:0]   digit;
	logic                        is_last;
	logic                        blank;
	logic [ddf_pkg::COL_W-1:0]   step;

	assign cnt_clamp = (in_data.digit_count > MAX_CNT) ? MAX_CNT : in_data.digit_count;

	// add 3 to every bcd digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			dig_a[i] = bcd_q[i*ddf_pkg::DIG_W +: ddf_pkg::DIG_W];
			adj_v[i*ddf_pkg::DIG_W +: ddf_pkg::DIG_W] = (dig_a[i] >= 4'd5) ?
				dig_a[i] + 4'd3 : dig_a[i];
		end
	end

	assign idx     = IDX_W'(rem_q - ONE);
	assign digit   = dig_a[idx];
	assign is_last = (rem_q == ONE);
	assign blank   = !shown_q && !is_last && (digit == '0);
	assign step    = font_height_q >> 1;

	assign sts.in_empty   = (cnt_clamp == '0);
	assign sts.out_free   = !out_valid_q || out_ready;
	assign sts.last_digit = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_height_q <= ddf_pkg::FH_RESET;
			out_valid_q   <= 1'b0;
			rem_q         <= '0;
		end else begin
			if (cfg_wr) begin
				font_height_q <= cfg_data;
			end
			if (cmd.load) begin
				rem_q <= CNT_W'(cnt_clamp);
			end else if (cmd.emit) begin
				rem_q <= rem_q - ONE;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q   <= in_data.value;
			bcd_q   <= '0;
			col_q   <= in_data.start_column;
			page_q  <= in_data.page;
			shown_q <= 1'b0;
		end else if (cmd.shift) begin
			bcd_q <= {adj_v[BCD_W-2:0], bin_q[ddf_pkg::VALUE_W-1]};
			bin_q <= bin_q << 1;
		end else if (cmd.emit) begin
			col_q   <= col_q + step;
			shown_q <= shown_q || !blank;
		end
		if (cmd.emit) begin
			out_q.char_code <= blank ? ddf_pkg::BLANK_CODE :
				ddf_pkg::ZERO_CODE + ddf_pkg::CHAR_W'(digit);
			out_q.column    <= col_q;
			out_q.page_out  <= page_q;
			out_q.last      <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- rtl/ddf_ctrl.sv -----
// controller: sequences load, sixteen conversion steps and per-digit emission
// depends on ddf_pkg

module ddf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ddf_pkg::sts_t  sts,
	output ddf_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CONV,
		S_EMIT
	} state_t;

	state_t                           state_q;
	logic [ddf_pkg::STEP_CNT_W-1:0]   step_q;

	assign in_ready  = (state_q == S_IDLE);
	assign cmd.load  = (state_q == S_IDLE) && in_valid;
	assign cmd.shift = (state_q == S_CONV);
	assign cmd.emit  = (state_q == S_EMIT) && sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && !sts.in_empty) begin
						state_q <= S_CONV;
						step_q  <= '0;
					end
				end
				S_CONV: begin
					step_q <= step_q + ddf_pkg::STEP_CNT_W'(1);
					if (step_q == ddf_pkg::LAST_STEP) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (sts.out_free && sts.last_digit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("emit while output register is occupied");

	a_load_starts_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && !sts.in_empty) |=> (state_q == S_CONV && step_q == '0))
		else $error("conversion did not start from step zero");

	a_conv_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CONV && step_q == ddf_pkg::LAST_STEP) |=> (state_q == S_EMIT))
		else $error("conversion did not hand over to emission");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && (cmd.shift || cmd.emit)) && !(cmd.shift && cmd.emit))
		else $error("datapath commands overlap");

endmodule

// ----- rtl/decimal_digit_formatter.sv -----
// top level of the decimal digit formatter: controller plus datapath
// depends on ddf_pkg, ddf_ifs, ddf_ctrl, ddf_datapath
//
//  channel    dir   payload                                     handshake
//  item_in    sink  value, digit_count, start_column, page      valid/ready
//  item_out   src   char_code, column, page_out, last           valid/ready
//  cfg        sink  font_height (8 bits)                        valid/ready, always ready
//
//  an item is loaded, put through sixteen shift-add-3 steps, then emitted one digit per cycle
//  while item_out has room; a zero count is only loaded and gives no character
//  most of the time per item goes to the sixteen-step serial bcd conversion
//  the next item is taken as soon as the last character sits in the output register
//  a stalled item_out holds emission but never loses a character
//  arst_n clears the state machine, the output valid flag and font_height to 16

module decimal_digit_formatter #(
	parameter int MAX_DIGITS = ddf_pkg::MAX_DIGITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ddf_in_if.sink    item_in,
	ddf_out_if.source item_out,
	ddf_cfg_if.sink   cfg
);

	ddf_pkg::cmd_t cmd;
	ddf_pkg::sts_t sts;

	// register write is taken every cycle
	assign cfg.ready = 1'b1;

	ddf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_in.valid),
		.in_ready (item_in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ddf_datapath #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (item_in.data),
		.cfg_wr    (cfg.valid),
		.cfg_data  (cfg.data),
		.out_valid (item_out.valid),
		.out_ready (item_out.ready),
		.out_data  (item_out.data)
	);

endmodule

// ----- sim/tb_top.sv -----
// self-checking testbench for decimal_digit_formatter
// depends on ddf_pkg, ddf_ifs and the rtl of the block; predicts every character itself

module tb_top;

	import ddf_pkg::*;

	localparam int DIGIT_LIMIT      = MAX_DIGITS_DEF;
	localparam int RANDOM_PER_PHASE = 30;
	// an item is loaded, converted and emitted inside the block, a zero count only loaded
	localparam int SETTLE_CYCLES    = 40;
	localparam int HOLD_CYCLES      = 400;
	localparam int WATCHDOG_LIMIT   = 3000;
	localparam int REPORT_LIMIT     = 10;

	// receiver stall patterns
	typedef enum int {RDY_ALWAYS, RDY_HALF, RDY_SPARSE} ready_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	ddf_in_if  in_ch ();
	ddf_out_if out_ch ();
	ddf_cfg_if cfg_ch ();

	decimal_digit_formatter #(
		.MAX_DIGITS(DIGIT_LIMIT)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_in (in_ch),
		.item_out(out_ch),
		.cfg     (cfg_ch)
	);

	always #10 clk = ~clk;

	// items waiting for the driver, characters waiting for the block
	item_in_t  pending_items[$];
	item_out_t expected_chars[$];

	// our copy of the register, updated when a write is accepted
	logic [FH_W-1:0] font_height_copy = FH_RESET;

	int fail_count = 0;
	int chars_seen = 0;

	// driver burst state
	int burst_left;
	int gap_left;

	// receiver state
	ready_mode_t rdy_mode;
	int mode_left;
	int hold_left;
	bit held_once = 1'b0;

	// turn one accepted item into its characters, most significant first
	function automatic void predict_chars(item_in_t it);
		int unsigned n;
		int unsigned divisor;
		int unsigned digit;
		int unsigned step;
		bit shown;
		bit is_last;
		item_out_t r;
		n = (it.digit_count > DIGIT_LIMIT) ? DIGIT_LIMIT : it.digit_count;
		step = font_height_copy >> 1;
		shown = 1'b0;
		for (int unsigned t = 0; t < n; t++) begin
			divisor = 1;
			for (int unsigned k = 0; k < n - 1 - t; k++)
				divisor = divisor * 10;
			digit = (int'(it.value) / divisor) % 10;
			is_last = (t + 1 == n);
			// leading zero blanking until the first nonzero, last digit always shown
			if (!shown && !is_last && digit == 0) begin
				r.char_code = BLANK_CODE;
			end else begin
				shown = 1'b1;
				r.char_code = ZERO_CODE + CHAR_W'(digit);
			end
			r.column   = COL_W'(int'(it.start_column) + step * t);
			r.page_out = it.page;
			r.last     = is_last;
			expected_chars.push_back(r);
		end
	endfunction

	function automatic item_in_t make_item(int unsigned v, int unsigned n, int unsigned col,
			int unsigned pg);
		item_in_t it;
		it.value        = VALUE_W'(v);
		it.digit_count  = COUNT_W'(n);
		it.start_column = COL_W'(col);
		it.page         = PAGE_W'(pg);
		return it;
	endfunction

	// mostly proper counts and full-range values, with small and zero values mixed in
	function automatic item_in_t random_item();
		item_in_t it;
		int unsigned sel;
		sel = $urandom_range(0, 99);
		it.value = VALUE_W'($urandom);
		if (sel < 15)
			it.value = VALUE_W'($urandom_range(0, 99));
		else if (sel < 22)
			it.value = '0;
		else if (sel < 32)
			it.value = VALUE_W'($urandom_range(0, 9999));
		if ($urandom_range(0, 99) < 88)
			it.digit_count = COUNT_W'($urandom_range(1, DIGIT_LIMIT));
		else
			it.digit_count = COUNT_W'($urandom_range(0, 7));
		it.start_column = COL_W'($urandom);
		it.page         = PAGE_W'($urandom);
		return it;
	endfunction

	// driver: hands out pending items in bursts with random gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data  <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				predict_chars(in_ch.data);
			// only move on once the offered item is gone
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_ch.valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					in_ch.valid <= 1'b1;
					in_ch.data  <= pending_items.pop_front();
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						// about half the bursts run back to back with no gap at all
						gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 30);
						burst_left = $urandom_range(1, 12);
					end
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each accepted character and drives the stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			rdy_mode  = RDY_ALWAYS;
			mode_left = 0;
			hold_left = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				chars_seen++;
				if (expected_chars.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("unexpected character: code %0d column %0d page %0d last %0d",
							out_ch.data.char_code, out_ch.data.column,
							out_ch.data.page_out, out_ch.data.last);
				end else begin
					if (out_ch.data.char_code !== expected_chars[0].char_code
							|| out_ch.data.column !== expected_chars[0].column
							|| out_ch.data.page_out !== expected_chars[0].page_out
							|| out_ch.data.last !== expected_chars[0].last) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display("mismatch at character %0d: expected code %0d column %0d page %0d last %0d, got code %0d column %0d page %0d last %0d",
								chars_seen,
								expected_chars[0].char_code, expected_chars[0].column,
								expected_chars[0].page_out, expected_chars[0].last,
								out_ch.data.char_code, out_ch.data.column,
								out_ch.data.page_out, out_ch.data.last);
					end
					void'(expected_chars.pop_front());
				end
			end
			// one long hold-off while the sender still has plenty queued, to back up the input
			if (!held_once && pending_items.size() >= 20 && chars_seen > 40) begin
				hold_left = HOLD_CYCLES;
				held_once = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rdy_mode  = ready_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(20, 80);
				end else begin
					mode_left--;
				end
				case (rdy_mode)
					RDY_ALWAYS: out_ch.ready <= 1'b1;
					RDY_HALF:   out_ch.ready <= ($urandom_range(0, 1) == 0);
					default:    out_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// watchdog: cycles with no handshake on any channel
	int idle_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout after %0d cycles without a handshake", idle_cycles);
				$display("decimal_digit_formatter verification failed");
				$finish;
			end
		end
	end

	// block is idle when nothing is queued, offered or outstanding,
	// plus a margin for a zero-count item that yields no character
	task automatic wait_idle();
		@(posedge clk);
		while (pending_items.size() != 0 || in_ch.valid || expected_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// called on a rising edge; holds valid until the write is taken
	task automatic write_font_height(input logic [FH_W-1:0] fh);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= fh;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		font_height_copy = fh;
		cfg_ch.valid <= 1'b0;
	endtask

	logic [FH_W-1:0] phase_heights[6];

	initial begin
		// x to 0 on reset also puts the driver and monitor into reset at time zero
		arst_n       <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data  <= '0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		// directed items at the reset font height (column step 8)
		pending_items.push_back(make_item(0, 5, 0, 0));          // zero value, all blank but last
		pending_items.push_back(make_item(0, 1, 10, 1));         // zero value, single position
		pending_items.push_back(make_item(65535, 5, 20, 7));     // largest value, all digits
		pending_items.push_back(make_item(65535, 1, 255, 2));    // only lowest digit kept
		pending_items.push_back(make_item(12345, 5, 30, 3));
		pending_items.push_back(make_item(100, 5, 40, 4));       // blanks then inner zeros shown
		pending_items.push_back(make_item(10000, 4, 50, 5));     // top digit dropped, all zero
		pending_items.push_back(make_item(1002, 3, 60, 6));      // dropped digit leaves "  2"
		pending_items.push_back(make_item(5, 2, 70, 0));
		pending_items.push_back(make_item(7, 1, 80, 1));
		pending_items.push_back(make_item(123, 0, 90, 2));       // zero count gives nothing
		pending_items.push_back(make_item(54321, 6, 100, 3));    // count clamped
		pending_items.push_back(make_item(9, 7, 110, 4));        // largest count clamped
		pending_items.push_back(make_item(40506, 5, 250, 5));    // columns wrap past 255
		pending_items.push_back(make_item(90, 2, 255, 6));       // wrap on the second digit
		pending_items.push_back(make_item(1, 5, 128, 7));
		pending_items.push_back(make_item(65535, 0, 255, 7));    // zero count, full fields
		pending_items.push_back(make_item(9999, 4, 1, 0));
		pending_items.push_back(make_item(10, 3, 2, 1));
		pending_items.push_back(make_item(32768, 5, 170, 2));

		// extremes first, then random settings and the reset value again
		phase_heights[0] = 8'd255;
		phase_heights[1] = 8'd0;
		phase_heights[2] = 8'd1;
		phase_heights[3] = FH_W'($urandom);
		phase_heights[4] = FH_RESET;
		phase_heights[5] = FH_W'($urandom);

		foreach (phase_heights[p]) begin
			wait_idle();
			write_font_height(phase_heights[p]);
			repeat (RANDOM_PER_PHASE)
				pending_items.push_back(random_item());
		end
		wait_idle();

		if (fail_count == 0) begin
			$display("decimal_digit_formatter verification clean");
		end else begin
			$display("decimal_digit_formatter verification failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/ddf_pkg.sv
rtl/ddf_ifs.sv
rtl/ddf_datapath.sv
rtl/ddf_ctrl.sv
rtl/decimal_digit_formatter.sv
sim/tb_top.sv
